[src/mcbd_pkg.sv]
// Shared types and constants for the mip chain box downsampler.
// Used by the level cell, the top level and the testbench.
// No dependencies.
package mcbd_pkg;

    localparam int MAX_SIZE_LOG2 = 10;
    localparam int LEVEL_W       = 4;
    localparam int COORD_W       = MAX_SIZE_LOG2;
    localparam int POS_W         = 9;
    localparam int CHAN_W        = 8;
    localparam int NUM_CHAN      = 4;
    localparam int PIX_W         = CHAN_W * NUM_CHAN;
    localparam int PSUM_W        = CHAN_W + 1;
    localparam int PAIR_W        = PSUM_W * NUM_CHAN;

    localparam logic [LEVEL_W-1:0] SIZE_RESET = LEVEL_W'(10);
    localparam logic [LEVEL_W-1:0] SIZE_MIN   = LEVEL_W'(1);
    localparam logic [LEVEL_W-1:0] SIZE_MAX   = LEVEL_W'(MAX_SIZE_LOG2);

    typedef logic [PIX_W-1:0]  pixel_t;
    typedef logic [PAIR_W-1:0] pair_t;

    // word handed from one level cell to the next
    typedef struct packed {
        logic   valid;
        pixel_t pix;
    } tok_t;

    // result word offered by a cell to the output register
    typedef struct packed {
        logic               fire;
        logic [LEVEL_W-1:0] level;
        logic [POS_W-1:0]   column;
        logic [POS_W-1:0]   line;
        pixel_t             pix;
        logic               last;
    } res_t;

endpackage

[src/mcbd_line_ram.sv]
// Simple dual-port line RAM, one write and one registered read per cycle.
// Holds the horizontal pair sums of one mip level. No package dependency.
module mcbd_line_ram #(
    parameter int ADDR_W = 9,
    parameter int DATA_W = 36
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[src/mcbd_level_cell.sv]
// One mip level of the chain: position counters, held left pixel and the
// pair-sum logic that averages a 2x2 block. Uses mcbd_pkg; its line buffer
// sits in an mcbd_line_ram next to it.
module mcbd_level_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [mcbd_pkg::LEVEL_W-1:0]  cell_index,
    input  logic [mcbd_pkg::LEVEL_W-1:0]  levels,
    input  logic                          restart,
    input  mcbd_pkg::tok_t                tok_in,
    input  logic                          out_free,
    input  logic                          next_emit,
    output logic                          will_emit,
    output logic                          busy,
    output mcbd_pkg::tok_t                tok_out,
    output mcbd_pkg::res_t                res,
    output logic                          ram_wr_en,
    output logic [mcbd_pkg::POS_W-1:0]    ram_wr_addr,
    output mcbd_pkg::pair_t               ram_wr_data,
    output logic [mcbd_pkg::POS_W-1:0]    ram_rd_addr,
    input  mcbd_pkg::pair_t               ram_rd_data
);

    import mcbd_pkg::*;

    logic                 tok_valid_reg, tok_valid_next;
    pixel_t               tok_pix_reg;
    pixel_t               held_reg;
    logic [COORD_W-1:0]   col_reg, col_next;
    logic [COORD_W-1:0]   row_reg, row_next;
    logic [LEVEL_W-1:0]   side_log2;
    logic [COORD_W-1:0]   wrap_mask;
    logic                 col_last, row_last;
    logic                 fire;
    logic                 emit;
    pair_t                pair;
    pixel_t               avg_pix;

    // side of the level above is 2^(levels - index + 1)
    assign side_log2 = levels - cell_index + LEVEL_W'(1);
    assign wrap_mask = ~({COORD_W{1'b1}} << side_log2);
    assign col_last  = (col_reg == wrap_mask);
    assign row_last  = (row_reg == wrap_mask);

    // an odd column on an odd row closes a 2x2 block
    assign will_emit = col_reg[0] & row_reg[0];
    assign emit      = will_emit;
    assign fire      = tok_valid_reg && (!emit || out_free);
    assign busy      = tok_valid_reg;

    // position counters advance on every processed pixel
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (fire)
        begin
            if (col_last)
            begin
                col_next = '0;
                row_next = row_last ? '0 : row_reg + COORD_W'(1);
            end
            else
            begin
                col_next = col_reg + COORD_W'(1);
            end
        end
    end

    // horizontal pair sums and the 2x2 average
    always_comb
    begin
        logic [PSUM_W:0] vsum;
        for (int ch = 0; ch < NUM_CHAN; ch++)
        begin
            pair[ch*PSUM_W +: PSUM_W] = PSUM_W'(held_reg[ch*CHAN_W +: CHAN_W])
                                      + PSUM_W'(tok_pix_reg[ch*CHAN_W +: CHAN_W]);
            vsum = (PSUM_W+1)'(ram_rd_data[ch*PSUM_W +: PSUM_W])
                 + (PSUM_W+1)'(pair[ch*PSUM_W +: PSUM_W]);
            avg_pix[ch*CHAN_W +: CHAN_W] = vsum[PSUM_W:2];
        end
    end

    // token stage
    always_comb
    begin
        tok_valid_next = tok_valid_reg;
        if (tok_in.valid)
        begin
            tok_valid_next = 1'b1;
        end
        else if (fire)
        begin
            tok_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
        end
        else if (restart)
        begin
            tok_valid_reg <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
        end
        else
        begin
            tok_valid_reg <= tok_valid_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (tok_in.valid)
        begin
            tok_pix_reg <= tok_in.pix;
        end
        if (fire && !col_reg[0])
        begin
            held_reg <= tok_pix_reg;
        end
    end

    // line buffer: even rows store, odd rows read back
    assign ram_wr_en   = fire && col_reg[0] && !row_reg[0];
    assign ram_wr_addr = col_reg[COORD_W-1:1];
    assign ram_wr_data = pair;
    assign ram_rd_addr = col_next[COORD_W-1:1];

    // hand the average to the next level
    assign tok_out.valid = fire && emit && (cell_index != levels);
    assign tok_out.pix   = avg_pix;

    assign res.fire   = fire && emit;
    assign res.level  = cell_index;
    assign res.column = col_reg[COORD_W-1:1];
    assign res.line   = row_reg[COORD_W-1:1];
    assign res.pix    = avg_pix;
    assign res.last   = (cell_index == levels) || !next_emit;

endmodule

[src/mip_chain_box_downsampler_core.sv]
// Top level of the mip chain box downsampler: size register, the chain of
// level cells with their line RAMs, and the output register.
// Uses mcbd_pkg, mcbd_level_cell and mcbd_line_ram.
//
// Usage:
// - Input channel (in_valid / in_stall) carries the top-level image as
//   RGBA8 words in raster order. Output channel (out_valid / out_stall)
//   carries the pixels of levels 1 .. size_log2 with their level, column
//   and line; last marks the final output word caused by one input word.
// - size_log2 is written through cfg_write_en / cfg_write_data while the
//   block is idle; each write restarts the frame. 0 acts as 1, values
//   above 10 act as 10. Reset sets it to 10 and clears all positions.
// - Each level is one cell; a word walks the chain one cell per cycle when
//   the receiver does not stall, and each result passes through the
//   output register on its way to the ports.
// - A word keeps the chain busy until it stops in a cell, so the input
//   takes a new word only once the chain is empty again.
// - A stalled output holds its word; the cell that produces the next
//   result waits in place and the input stays stalled until the chain is
//   empty again.
module mip_chain_box_downsampler_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write_en,
    input  logic [mcbd_pkg::LEVEL_W-1:0]   cfg_write_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [mcbd_pkg::CHAN_W-1:0]    red,
    input  logic [mcbd_pkg::CHAN_W-1:0]    green,
    input  logic [mcbd_pkg::CHAN_W-1:0]    blue,
    input  logic [mcbd_pkg::CHAN_W-1:0]    alpha,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [mcbd_pkg::LEVEL_W-1:0]   level,
    output logic [mcbd_pkg::POS_W-1:0]     column,
    output logic [mcbd_pkg::POS_W-1:0]     line,
    output logic [mcbd_pkg::CHAN_W-1:0]    out_red,
    output logic [mcbd_pkg::CHAN_W-1:0]    out_green,
    output logic [mcbd_pkg::CHAN_W-1:0]    out_blue,
    output logic [mcbd_pkg::CHAN_W-1:0]    out_alpha,
    output logic                           last
);

    import mcbd_pkg::*;

    logic [LEVEL_W-1:0]   size_reg;
    logic [LEVEL_W-1:0]   levels;
    logic                 accept;
    logic                 out_free;
    logic                 chain_busy;
    tok_t                 tok_link [MAX_SIZE_LOG2+1];
    logic                 emit_flag [MAX_SIZE_LOG2+1];
    logic                 busy_vec [MAX_SIZE_LOG2];
    res_t                 res_vec [MAX_SIZE_LOG2];
    res_t                 res_sel;
    logic                 out_valid_reg, out_valid_next;
    res_t                 out_reg;

    // size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_RESET;
        end
        else if (cfg_write_en)
        begin
            size_reg <= cfg_write_data;
        end
    end

    // clamp the size to the supported range
    always_comb
    begin
        if (size_reg < SIZE_MIN)
        begin
            levels = SIZE_MIN;
        end
        else if (size_reg > SIZE_MAX)
        begin
            levels = SIZE_MAX;
        end
        else
        begin
            levels = size_reg;
        end
    end

    // input handshake: one word in the chain at a time
    always_comb
    begin
        chain_busy = 1'b0;
        for (int i = 0; i < MAX_SIZE_LOG2; i++)
        begin
            chain_busy = chain_busy | busy_vec[i];
        end
    end

    assign in_stall = chain_busy;
    assign accept   = in_valid && !chain_busy;

    assign tok_link[0].valid = accept;
    assign tok_link[0].pix   = {alpha, blue, green, red};
    assign emit_flag[MAX_SIZE_LOG2] = 1'b0;

    // chain of level cells, each with its own line buffer
    for (genvar g = 0; g < MAX_SIZE_LOG2; g++)
    begin : g_level
        localparam int AW = (MAX_SIZE_LOG2 - g - 1 > 0) ? MAX_SIZE_LOG2 - g - 1 : 1;

        logic               wr_en;
        logic [POS_W-1:0]   wr_addr;
        pair_t              wr_data;
        logic [POS_W-1:0]   rd_addr;
        pair_t              rd_data;

        mcbd_level_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cell_index  (LEVEL_W'(g + 1)),
            .levels      (levels),
            .restart     (cfg_write_en),
            .tok_in      (tok_link[g]),
            .out_free    (out_free),
            .next_emit   (emit_flag[g+1]),
            .will_emit   (emit_flag[g]),
            .busy        (busy_vec[g]),
            .tok_out     (tok_link[g+1]),
            .res         (res_vec[g]),
            .ram_wr_en   (wr_en),
            .ram_wr_addr (wr_addr),
            .ram_wr_data (wr_data),
            .ram_rd_addr (rd_addr),
            .ram_rd_data (rd_data)
        );

        mcbd_line_ram #(
            .ADDR_W (AW),
            .DATA_W (PAIR_W)
        ) u_ram (
            .clk     (clk),
            .wr_en   (wr_en),
            .wr_addr (wr_addr[AW-1:0]),
            .wr_data (wr_data),
            .rd_addr (rd_addr[AW-1:0]),
            .rd_data (rd_data)
        );
    end

    // at most one cell fires per cycle
    always_comb
    begin
        res_sel = '0;
        for (int i = 0; i < MAX_SIZE_LOG2; i++)
        begin
            if (res_vec[i].fire)
            begin
                res_sel = res_sel | res_vec[i];
            end
        end
    end

    // output register
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_sel.fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_sel.fire)
        begin
            out_reg <= res_sel;
        end
    end

    assign out_valid = out_valid_reg;
    assign level     = out_reg.level;
    assign column    = out_reg.column;
    assign line      = out_reg.line;
    assign out_red   = out_reg.pix[0*CHAN_W +: CHAN_W];
    assign out_green = out_reg.pix[1*CHAN_W +: CHAN_W];
    assign out_blue  = out_reg.pix[2*CHAN_W +: CHAN_W];
    assign out_alpha = out_reg.pix[3*CHAN_W +: CHAN_W];
    assign last      = out_reg.last;

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for mip_chain_box_downsampler_core: streams square frames
// of RGBA8 words and checks every mip word against an in-bench 2x2 box filter chain.
// Depends on mcbd_pkg and the core RTL only.
module testbench;
    import mcbd_pkg::*;

    localparam int LINE_DEPTH     = (1 << MAX_SIZE_LOG2) - 1;
    localparam int IDLE_PCT       = 26;
    localparam int SETTLE_CYCLES  = MAX_SIZE_LOG2 + 4;
    localparam int RANDOM_WORDS   = 430;
    localparam int CALM_FROM      = 120;
    localparam int CALM_TO        = 260;
    // no acceptance for this long means the core hung
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum logic [1:0] {
        SEND_PIXEL,
        SEND_SIZE,
        SEND_HOLD
    } send_kind_t;

    typedef struct {
        send_kind_t         kind;
        pixel_t             pix;
        logic [LEVEL_W-1:0] size_val;
    } send_word_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [POS_W-1:0]   column;
        logic [POS_W-1:0]   line;
        pixel_t             pix;
        logic               last;
    } mip_word_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_write_en = 1'b0;
    logic [LEVEL_W-1:0] cfg_write_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [CHAN_W-1:0]  red = '0;
    logic [CHAN_W-1:0]  green = '0;
    logic [CHAN_W-1:0]  blue = '0;
    logic [CHAN_W-1:0]  alpha = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [LEVEL_W-1:0] level;
    logic [POS_W-1:0]   column;
    logic [POS_W-1:0]   line;
    logic [CHAN_W-1:0]  out_red;
    logic [CHAN_W-1:0]  out_green;
    logic [CHAN_W-1:0]  out_blue;
    logic [CHAN_W-1:0]  out_alpha;
    logic               last;

    // stimulus and expectations
    send_word_t pending_words[$];
    mip_word_t  mip_expected[$];

    // mirror of the level chain
    logic [LEVEL_W-1:0] mirror_size;
    pixel_t             held_px[1:MAX_SIZE_LOG2];
    int                 level_col[1:MAX_SIZE_LOG2];
    int                 level_row[1:MAX_SIZE_LOG2];
    pair_t              pair_lines[0:LINE_DEPTH-1];

    int   fail_count = 0;
    int   words_in = 0;
    int   words_out = 0;
    int   size_writes = 0;
    int   holds_done = 0;
    int   random_words = 0;
    int   quiet_run = 0;
    int   dead_run = 0;
    logic calm = 1'b0;

    always #4 clk = ~clk;

    mip_chain_box_downsampler_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .alpha          (alpha),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .level          (level),
        .column         (column),
        .line           (line),
        .out_red        (out_red),
        .out_green      (out_green),
        .out_blue       (out_blue),
        .out_alpha      (out_alpha),
        .last           (last)
    );

    // number of levels a size setting really produces
    function automatic int live_levels(input logic [LEVEL_W-1:0] v);
        if (v < SIZE_MIN)
            return int'(SIZE_MIN);
        if (v > SIZE_MAX)
            return int'(SIZE_MAX);
        return int'(v);
    endfunction

    // size write: new frame, positions and held pixels cleared
    function automatic void restart_mirror(input logic [LEVEL_W-1:0] v);
        mirror_size = v;
        for (int k = 1; k <= MAX_SIZE_LOG2; k++)
        begin
            held_px[k]   = '0;
            level_col[k] = 0;
            level_row[k] = 0;
        end
    endfunction

    // walk one top-level word down the chain, queue the mip words it completes
    function automatic void predict_mip_words(input pixel_t top_px);
        int                levels;
        int                side;
        int                c;
        int                r;
        int                pos;
        pixel_t            cur;
        pixel_t            avg;
        pair_t             pair;
        pair_t             prev;
        logic [PSUM_W:0]   acc;
        mip_word_t         word;
        mip_word_t         held_word;
        logic              have_word;
        levels    = live_levels(mirror_size);
        cur       = top_px;
        have_word = 1'b0;
        held_word = '0;
        for (int k = 1; k <= levels; k++)
        begin
            side = 1 << (levels - k + 1);
            c    = level_col[k];
            r    = level_row[k];
            if (c + 1 >= side)
            begin
                level_col[k] = 0;
                level_row[k] = (r + 1 >= side) ? 0 : r + 1;
            end
            else
                level_col[k] = c + 1;
            // even column: just remember the left pixel
            if (c % 2 == 0)
            begin
                held_px[k] = cur;
                break;
            end
            for (int ch = 0; ch < NUM_CHAN; ch++)
                pair[PSUM_W*ch +: PSUM_W] = PSUM_W'(held_px[k][CHAN_W*ch +: CHAN_W])
                                          + PSUM_W'(cur[CHAN_W*ch +: CHAN_W]);
            pos = (1 << MAX_SIZE_LOG2) - (1 << (MAX_SIZE_LOG2 - k + 1)) + c / 2;
            if (pos >= LINE_DEPTH)
                break;
            // even row: store the pair sum for the row below
            if (r % 2 == 0)
            begin
                pair_lines[pos] = pair;
                break;
            end
            prev = pair_lines[pos];
            for (int ch = 0; ch < NUM_CHAN; ch++)
            begin
                acc = (PSUM_W+1)'(prev[PSUM_W*ch +: PSUM_W])
                    + (PSUM_W+1)'(pair[PSUM_W*ch +: PSUM_W]);
                avg[CHAN_W*ch +: CHAN_W] = acc[PSUM_W:2];
            end
            word.level  = LEVEL_W'(k);
            word.column = POS_W'(c >> 1);
            word.line   = POS_W'(r >> 1);
            word.pix    = avg;
            word.last   = 1'b0;
            if (have_word)
                mip_expected.push_back(held_word);
            held_word = word;
            have_word = 1'b1;
            cur = avg;
        end
        if (have_word)
        begin
            held_word.last = 1'b1;
            mip_expected.push_back(held_word);
        end
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    task automatic push_pixel(input int r, input int g, input int b, input int a);
        send_word_t w;
        w.kind     = SEND_PIXEL;
        w.pix      = {CHAN_W'(a), CHAN_W'(b), CHAN_W'(g), CHAN_W'(r)};
        w.size_val = '0;
        pending_words.push_back(w);
    endtask

    task automatic add_size(input int v);
        send_word_t w;
        w.kind     = SEND_SIZE;
        w.pix      = '0;
        w.size_val = LEVEL_W'(v);
        pending_words.push_back(w);
    endtask

    // random pixels, optionally with a full drain before word hold_at
    task automatic add_random_pixels(input int n, input int hold_at);
        send_word_t w;
        int         mode;
        for (int i = 0; i < n; i++)
        begin
            if (i == hold_at)
            begin
                w.kind     = SEND_HOLD;
                w.pix      = '0;
                w.size_val = '0;
                pending_words.push_back(w);
            end
            mode = $urandom_range(0, 9);
            w.kind     = SEND_PIXEL;
            w.size_val = '0;
            if (mode == 0)
                w.pix = '0;
            else if (mode == 1)
                w.pix = '1;
            else
                w.pix = pixel_t'($urandom);
            pending_words.push_back(w);
            random_words++;
        end
    endtask

    // driver: pixels, size writes and drain points from the pending queue
    always @(posedge clk or negedge rst_n)
    begin
        send_word_t head;
        logic       nxt_valid;
        logic       nxt_we;
        if (!rst_n)
        begin
            in_valid       <= 1'b0;
            cfg_write_en   <= 1'b0;
            cfg_write_data <= '0;
            red            <= '0;
            green          <= '0;
            blue           <= '0;
            alpha          <= '0;
            quiet_run      = 0;
        end
        else
        begin
            if (in_valid || out_valid || cfg_write_en)
                quiet_run = 0;
            else
                quiet_run++;
            nxt_we = 1'b0;
            if (!in_valid || !in_stall)
            begin
                nxt_valid = 1'b0;
                if (pending_words.size() != 0 && !cfg_write_en)
                begin
                    head = pending_words[0];
                    case (head.kind)
                        SEND_PIXEL:
                        begin
                            if (calm || $urandom_range(0, 99) >= IDLE_PCT)
                            begin
                                red       <= head.pix[CHAN_W*0 +: CHAN_W];
                                green     <= head.pix[CHAN_W*1 +: CHAN_W];
                                blue      <= head.pix[CHAN_W*2 +: CHAN_W];
                                alpha     <= head.pix[CHAN_W*3 +: CHAN_W];
                                nxt_valid = 1'b1;
                                void'(pending_words.pop_front());
                            end
                        end
                        SEND_SIZE:
                        begin
                            // only once the chain has fully drained
                            if (mip_expected.size() == 0 && quiet_run >= SETTLE_CYCLES)
                            begin
                                cfg_write_data <= head.size_val;
                                nxt_we = 1'b1;
                                restart_mirror(head.size_val);
                                size_writes++;
                                void'(pending_words.pop_front());
                            end
                        end
                        default:
                        begin
                            // wait until no word is offered and every predicted mip word has arrived
                            if (mip_expected.size() == 0 && !in_valid)
                            begin
                                holds_done++;
                                void'(pending_words.pop_front());
                            end
                        end
                    endcase
                end
                in_valid <= nxt_valid;
            end
            cfg_write_en <= nxt_we;
        end
    end

    // receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // monitor: check mip words, predict from accepted pixels, watchdog
    always @(posedge clk or negedge rst_n)
    begin
        mip_word_t got;
        mip_word_t want;
        logic      moved;
        if (!rst_n)
        begin
            calm     <= 1'b0;
            dead_run = 0;
        end
        else
        begin
            moved = 1'b0;
            if (out_valid && !out_stall)
            begin
                got = '{level, column, line, {out_alpha, out_blue, out_green, out_red}, last};
                moved = 1'b1;
                words_out++;
                if (mip_expected.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, actual level %0d col %0d line %0d",
                             $time, got.level, got.column, got.line);
                    fail_count++;
                end
                else
                begin
                    want = mip_expected.pop_front();
                    check_field("level", want.level, got.level);
                    check_field("column", want.column, got.column);
                    check_field("line", want.line, got.line);
                    check_field("out_red", want.pix[7:0], got.pix[7:0]);
                    check_field("out_green", want.pix[15:8], got.pix[15:8]);
                    check_field("out_blue", want.pix[23:16], got.pix[23:16]);
                    check_field("out_alpha", want.pix[31:24], got.pix[31:24]);
                    check_field("last", want.last, got.last);
                end
            end
            if (in_valid && !in_stall)
            begin
                predict_mip_words({alpha, blue, green, red});
                moved = 1'b1;
                words_in++;
            end
            calm <= (words_in >= CALM_FROM && words_in < CALM_TO);
            if (moved || cfg_write_en)
                dead_run = 0;
            else
                dead_run++;
            if (dead_run >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog, nothing accepted for %0d cycles", $time, dead_run);
                $display("simulation failed");
                $finish;
            end
        end
    end

    // stimulus, reset and end of run
    initial
    begin
        int pick;
        int sz;
        int n;
        logic aligned;
        restart_mirror(SIZE_RESET);
        for (int i = 0; i < LINE_DEPTH; i++)
            pair_lines[i] = '0;

        // two words at the reset size, then restart by a write
        push_pixel(255, 255, 255, 255);
        push_pixel(0, 0, 0, 0);
        // smallest frame, all ones
        add_size(SIZE_MIN);
        for (int i = 0; i < 4; i++)
            push_pixel(255, 255, 255, 255);
        // size zero acts as one, truncating sums
        add_size(0);
        push_pixel(255, 0, 255, 0);
        push_pixel(0, 255, 0, 255);
        push_pixel(255, 255, 0, 0);
        push_pixel(254, 255, 255, 254);
        // 4x4 frame, last pixel completes two levels
        add_size(2);
        for (int i = 0; i < 16; i++)
            push_pixel(i * 17, 255 - i * 17, (i % 2) * 255, i * 16 + 3);

        // oversized setting acts as the top size, cut short
        add_size(15);
        add_random_pixels(12, -1);
        // one bigger frame with a full drain in the middle
        add_size(4);
        add_random_pixels(256, 100);
        aligned = 1'b1;
        sz = 4;
        while (random_words < RANDOM_WORDS)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 2)
            begin
                // broken frame at any setting
                add_size($urandom_range(0, 15));
                add_random_pixels($urandom_range(1, 40), -1);
                aligned = 1'b0;
            end
            else
            begin
                n = $urandom_range(0, 3);
                if (!aligned || live_levels(LEVEL_W'(n)) != sz || $urandom_range(0, 1) == 1)
                    add_size(n);
                sz = live_levels(LEVEL_W'(n));
                aligned = 1'b1;
                add_random_pixels(1 << (2 * sz),
                                  ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : -1);
            end
        end

        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() != 0 || in_valid || mip_expected.size() != 0)
            @(posedge clk);
        repeat (4 * MAX_SIZE_LOG2) @(posedge clk);
        if (mip_expected.size() != 0)
        begin
            $display("%0t: %0d mip words never arrived", $time, mip_expected.size());
            fail_count++;
        end

        $display("run covered %0d pixels in, %0d mip words out, %0d size writes, %0d drains",
                 words_in, words_out, size_writes, holds_done);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
